>>> rtl/core/atb_pkg.sv
// Shared types and constants for the arc to cubic Bezier segment block.
// Used by every module under rtl/core; depends on nothing.
package atb_pkg;

    // Angle encoding, unsigned Q3.16 radians
    localparam int ANG_W = 19;
    localparam logic [ANG_W-1:0] ANG_Q1   = 19'd102944;
    localparam logic [ANG_W-1:0] ANG_Q2   = 19'd205887;
    localparam logic [ANG_W-1:0] ANG_Q3   = 19'd308831;
    localparam logic [ANG_W-1:0] ANG_FULL = 19'd411775;

    // Remainder angle fits in 17 bits (at most one quarter turn)
    localparam int REM_W = 17;

    // CORDIC datapath, Q1.30 points carried in 33-bit two's complement
    localparam int CW           = 33;
    localparam int CORDIC_STEPS = 30;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [CW-1:0] ONE30       = 33'sd1073741824;
    localparam logic signed [CW-1:0] QBETA       = 33'sd593011235;

    // Control factor, unsigned Q30 in 31 bits
    localparam int BW = 31;
    localparam logic [BW-1:0] BETA_MAX = 31'd805306368;

    // Half an LSB for rounding a Q60 product to Q30
    localparam int RND_HALF = 536870912;

    // Config register indexes
    typedef enum logic [2:0] {
        REG_M_XX     = 3'd0,
        REG_M_YX     = 3'd1,
        REG_M_XY     = 3'd2,
        REG_M_YY     = 3'd3,
        REG_OFFSET_X = 3'd4,
        REG_OFFSET_Y = 3'd5
    } reg_idx_t;

    // Arc bookkeeping that rides alongside the datapath
    typedef struct packed {
        logic [2:0] nq;     // number of quarter segments, 0..4
        logic       rzero;  // remainder is zero, no remainder segment
    } side_t;

    // CORDIC state for both lanes: full remainder and half remainder
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic signed [CW-1:0] x2;
        logic signed [CW-1:0] y2;
        logic signed [CW-1:0] z2;
        side_t                side;
    } cord_t;

    // Remainder segment ingredients after the divider
    typedef struct packed {
        logic [BW-1:0]        beta;
        logic signed [CW-1:0] c;
        logic signed [CW-1:0] s;
        side_t                side;
    } rem_t;

    // One segment before the transform: c1x c1y c2x c2y ex ey
    typedef struct packed {
        logic [5:0][CW-1:0] pt;
        logic               last;
    } seg_t;

    // Affine transform coefficients
    typedef struct packed {
        logic signed [31:0] m_xx;
        logic signed [31:0] m_yx;
        logic signed [31:0] m_xy;
        logic signed [31:0] m_yy;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
    } cfg_t;

    // Truncated Q30 arctangent table
    function automatic logic signed [CW-1:0] atan_at(input int i);
        logic signed [CW-1:0] v;
        case (i)
            0:  v = 33'sd843314856;
            1:  v = 33'sd497837829;
            2:  v = 33'sd263043836;
            3:  v = 33'sd133525158;
            4:  v = 33'sd67021686;
            5:  v = 33'sd33543515;
            6:  v = 33'sd16775850;
            7:  v = 33'sd8388437;
            8:  v = 33'sd4194282;
            9:  v = 33'sd2097149;
            10: v = 33'sd1048575;
            11: v = 33'sd524287;
            12: v = 33'sd262143;
            13: v = 33'sd131071;
            14: v = 33'sd65535;
            15: v = 33'sd32767;
            16: v = 33'sd16383;
            17: v = 33'sd8191;
            18: v = 33'sd4095;
            19: v = 33'sd2047;
            20: v = 33'sd1023;
            21: v = 33'sd511;
            22: v = 33'sd255;
            23: v = 33'sd127;
            24: v = 33'sd63;
            25: v = 33'sd31;
            26: v = 33'sd15;
            27: v = 33'sd7;
            28: v = 33'sd3;
            29: v = 33'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/atb_cordic.sv
// Angle decode and 30-stage dual-lane CORDIC pipeline (sin/cos of r and r/2).
// Depends on atb_pkg.
module atb_cordic (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [18:0]             arc_angle,
    output logic                    out_valid,
    input  logic                    out_ready,
    output atb_pkg::cord_t          out_data
);
    import atb_pkg::*;

    cord_t                  st_reg [CORDIC_STEPS];
    logic [CORDIC_STEPS-1:0] v_reg;
    logic [CORDIC_STEPS:0]   rdy;
    cord_t                  init_w;

    // One rotation step on both lanes
    function automatic cord_t step(input cord_t s, input int i);
        cord_t n;
        logic signed [CW-1:0] a;
        a = atan_at(i);
        n = s;
        if (s.z >= 0) begin
            n.x = s.x - (s.y >>> i);
            n.y = s.y + (s.x >>> i);
            n.z = s.z - a;
        end else begin
            n.x = s.x + (s.y >>> i);
            n.y = s.y - (s.x >>> i);
            n.z = s.z + a;
        end
        if (s.z2 >= 0) begin
            n.x2 = s.x2 - (s.y2 >>> i);
            n.y2 = s.y2 + (s.x2 >>> i);
            n.z2 = s.z2 - a;
        end else begin
            n.x2 = s.x2 + (s.y2 >>> i);
            n.y2 = s.y2 - (s.x2 >>> i);
            n.z2 = s.z2 + a;
        end
        return n;
    endfunction

    // Quarter count and remainder from the input angle
    always_comb begin
        logic [ANG_W-1:0] beg;
        logic [ANG_W-1:0] r;
        beg = '0;
        init_w.side.nq = 3'd0;
        if (arc_angle > ANG_Q1) begin
            init_w.side.nq = 3'd1;
            beg = ANG_Q1;
        end
        if (arc_angle > ANG_Q2) begin
            init_w.side.nq = 3'd2;
            beg = ANG_Q2;
        end
        if (arc_angle > ANG_Q3) begin
            init_w.side.nq = 3'd3;
            beg = ANG_Q3;
        end
        r = arc_angle - beg;
        if (arc_angle >= ANG_FULL) begin
            init_w.side.nq = 3'd4;
            r = '0;
        end
        init_w.side.rzero = (r == '0);
        init_w.x  = CORDIC_GAIN;
        init_w.y  = '0;
        init_w.z  = $signed({2'b00, r[REM_W-1:0], 14'd0});
        init_w.x2 = CORDIC_GAIN;
        init_w.y2 = '0;
        init_w.z2 = $signed({3'b000, r[REM_W-1:0], 13'd0});
    end

    // Ready ripples back through empty slots
    assign rdy[CORDIC_STEPS] = out_ready;
    assign in_ready          = rdy[0];

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
        cord_t src;
        logic  src_v;
        if (i == 0) begin : g_first
            assign src   = init_w;
            assign src_v = in_valid;
        end else begin : g_rest
            assign src   = st_reg[i-1];
            assign src_v = v_reg[i-1];
        end

        assign rdy[i] = !v_reg[i] || rdy[i+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (rdy[i]) begin
                v_reg[i] <= src_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[i]) begin
                st_reg[i] <= step(src, i);
            end
        end
    end

    assign out_valid = v_reg[CORDIC_STEPS-1];
    assign out_data  = st_reg[CORDIC_STEPS-1];

endmodule

>>> rtl/core/atb_div.sv
// Control factor: numerator/denominator setup and a one-bit-per-stage
// restoring divider with clamp. Depends on atb_pkg.
module atb_div (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  atb_pkg::cord_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output atb_pkg::rem_t   out_data
);
    import atb_pkg::*;

    localparam int QW = 31;           // quotient bits before overflow
    localparam int DW = 34;           // divisor width (2 * 3 * sin)
    localparam int NW = 65;           // dividend width
    localparam int NS = QW + 2;       // setup + divide stages + finish

    typedef struct packed {
        logic [DW-1:0]        rem;
        logic [QW-1:0]        nlo;
        logic [QW-1:0]        q;
        logic [DW-1:0]        dv;
        logic                 ovf;
        logic                 sneg;
        logic signed [CW-1:0] c;
        logic signed [CW-1:0] s;
        side_t                side;
    } div_t;

    div_t          st_reg [NS-1];
    rem_t          fin_reg;
    logic [NS-1:0] v_reg;
    logic [NS:0]   rdy;
    div_t          setup_w;
    rem_t          fin_w;

    // Setup: num = 1 - cos(r/2), d = 3 sin(r/2), N = num*2^33 + d, D = 2d
    always_comb begin
        logic signed [CW:0] num_s;
        logic [QW-1:0]      num;
        logic [32:0]        d;
        logic [NW-1:0]      n_full;
        num_s = {ONE30[CW-1], ONE30} - {in_data.x2[CW-1], in_data.x2};
        num   = num_s[CW] ? '0 : num_s[QW-1:0];
        d     = 33'(in_data.y2[31:0]) * 33'd3;
        n_full = {num, 33'd0} + NW'(d);
        setup_w.dv   = {d, 1'b0};
        setup_w.ovf  = (n_full[NW-1:QW] >= setup_w.dv);
        setup_w.rem  = n_full[NW-1:QW];
        setup_w.nlo  = n_full[QW-1:0];
        setup_w.q    = '0;
        setup_w.sneg = (in_data.y2 <= 0);
        setup_w.c    = in_data.x;
        setup_w.s    = in_data.y;
        setup_w.side = in_data.side;
    end

    // One quotient bit per stage
    function automatic div_t dstep(input div_t a);
        div_t          n;
        logic [DW:0]   sh;
        n  = a;
        sh = {a.rem, a.nlo[QW-1]};
        n.nlo = {a.nlo[QW-2:0], 1'b0};
        if (sh >= {1'b0, a.dv}) begin
            n.rem = DW'(sh - {1'b0, a.dv});
            n.q   = {a.q[QW-2:0], 1'b1};
        end else begin
            n.rem = sh[DW-1:0];
            n.q   = {a.q[QW-2:0], 1'b0};
        end
        return n;
    endfunction

    // Finish: zero on non-positive sine, clamp at 0.75
    always_comb begin
        div_t l;
        l = st_reg[NS-2];
        if (l.sneg) begin
            fin_w.beta = '0;
        end else if (l.ovf || l.q > BETA_MAX) begin
            fin_w.beta = BETA_MAX;
        end else begin
            fin_w.beta = l.q;
        end
        fin_w.c    = l.c;
        fin_w.s    = l.s;
        fin_w.side = l.side;
    end

    assign rdy[NS]  = out_ready;
    assign in_ready = rdy[0];

    for (genvar i = 0; i < NS; i++) begin : g_stage
        assign rdy[i] = !v_reg[i] || rdy[i+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (rdy[i]) begin
                v_reg[i] <= (i == 0) ? in_valid : v_reg[(i == 0) ? 0 : i-1];
            end
        end

        if (i == 0) begin : g_setup
            always_ff @(posedge aclk) begin
                if (rdy[i]) begin
                    st_reg[i] <= setup_w;
                end
            end
        end else if (i < NS-1) begin : g_divide
            always_ff @(posedge aclk) begin
                if (rdy[i]) begin
                    st_reg[i] <= dstep(st_reg[i-1]);
                end
            end
        end else begin : g_finish
            always_ff @(posedge aclk) begin
                if (rdy[i]) begin
                    fin_reg <= fin_w;
                end
            end
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_data  = fin_reg;

endmodule

>>> rtl/core/atb_seg.sv
// Remainder control points (product stage, then hold stage) and the segment
// sequencer that expands one arc into up to four segments. Depends on atb_pkg.
module atb_seg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  atb_pkg::rem_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output atb_pkg::seg_t  out_data
);
    import atb_pkg::*;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } pt_t;

    // Stage A: products
    logic                 va_reg;
    rem_t                 a_reg;
    logic signed [64:0]   pbs_reg;
    logic signed [64:0]   pbc_reg;

    // Hold stage: one arc being expanded
    logic                 hv_reg;
    rem_t                 h_reg;
    logic signed [CW-1:0] p2_reg;
    logic signed [CW-1:0] p3_reg;
    logic [1:0]           k_reg;
    logic [1:0]           k_next;

    logic                 rdy_a;
    logic                 hold_load;
    logic [2:0]           nseg;
    logic                 seg_last;
    logic signed [64:0]   rbs;
    logic signed [64:0]   rbc;
    logic signed [CW-1:0] p2_w;
    logic signed [CW-1:0] p3_w;

    function automatic pt_t rot(input logic [1:0] k, input pt_t p);
        pt_t r;
        case (k)
            2'd1:    begin r.x = -p.y; r.y =  p.x; end
            2'd2:    begin r.x = -p.x; r.y = -p.y; end
            2'd3:    begin r.x =  p.y; r.y = -p.x; end
            default: r = p;
        endcase
        return r;
    endfunction

    // Segment count and end-of-arc detect
    assign nseg      = h_reg.side.nq + {2'b00, !h_reg.side.rzero};
    assign seg_last  = ({1'b0, k_reg} == nseg - 3'd1);
    assign hold_load = !hv_reg || (nseg == 3'd0) || (seg_last && out_ready);
    assign rdy_a     = !va_reg || hold_load;
    assign in_ready  = rdy_a;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (rdy_a) begin
            va_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_a) begin
            a_reg   <= in_data;
            pbs_reg <= $signed({1'b0, in_data.beta}) * in_data.s;
            pbc_reg <= $signed({1'b0, in_data.beta}) * in_data.c;
        end
    end

    // Round Q60 products to Q30, form the inner control point
    assign rbs  = (pbs_reg + 65'(RND_HALF)) >>> 30;
    assign rbc  = (pbc_reg + 65'(RND_HALF)) >>> 30;
    assign p2_w = a_reg.c + $signed(rbs[CW-1:0]);
    assign p3_w = a_reg.s - $signed(rbc[CW-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hv_reg <= 1'b0;
        end else if (hold_load) begin
            hv_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (hold_load) begin
            h_reg  <= a_reg;
            p2_reg <= p2_w;
            p3_reg <= p3_w;
        end
    end

    // Segment index within the arc
    always_comb begin
        k_next = k_reg;
        if (hold_load) begin
            k_next = 2'd0;
        end else if (out_valid && out_ready) begin
            k_next = k_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= 2'd0;
        end else begin
            k_reg <= k_next;
        end
    end

    // Point selection and quadrant rotation
    always_comb begin
        logic       quart;
        logic [1:0] kr;
        pt_t        c1, c2, e;
        quart = ({1'b0, k_reg} < h_reg.side.nq);
        kr    = quart ? k_reg : h_reg.side.nq[1:0];
        if (quart) begin
            c1 = '{x: ONE30, y: QBETA};
            c2 = '{x: QBETA, y: ONE30};
            e  = '{x: '0,    y: ONE30};
        end else begin
            c1 = '{x: ONE30,   y: $signed({2'b00, h_reg.beta})};
            c2 = '{x: p2_reg,  y: p3_reg};
            e  = '{x: h_reg.c, y: h_reg.s};
        end
        c1 = rot(kr, c1);
        c2 = rot(kr, c2);
        e  = rot(kr, e);
        out_data.pt[0] = c1.x;
        out_data.pt[1] = c1.y;
        out_data.pt[2] = c2.x;
        out_data.pt[3] = c2.y;
        out_data.pt[4] = e.x;
        out_data.pt[5] = e.y;
        out_data.last  = seg_last;
    end

    assign out_valid = hv_reg && (nseg != 3'd0);

endmodule

>>> rtl/core/atb_xform.sv
// Affine transform of three control points: product stage, then sum,
// round, offset and saturate into the output register. Depends on atb_pkg.
module atb_xform (
    input  logic           aclk,
    input  logic           aresetn,
    input  atb_pkg::cfg_t  cfg,
    input  logic           in_valid,
    output logic           in_ready,
    input  atb_pkg::seg_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [5:0][31:0] out_coord,
    output logic           out_last
);
    import atb_pkg::*;

    logic                v1_reg;
    logic                v2_reg;
    logic                l1_reg;
    logic                l2_reg;
    logic signed [64:0]  pa_reg [6];
    logic signed [64:0]  pb_reg [6];
    logic [31:0]         o_reg  [6];
    logic                rdy1;
    logic                rdy2;

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            l1_reg <= in_data.last;
        end
        if (rdy2) begin
            l2_reg <= l1_reg;
        end
    end

    // Even coordinates are x outputs, odd ones y outputs
    for (genvar o = 0; o < 6; o++) begin : g_coord
        logic signed [31:0] ca;
        logic signed [31:0] cb;
        logic signed [31:0] off;
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic signed [65:0] sum;
        logic signed [65:0] rs;
        logic signed [36:0] v;

        assign ca  = (o % 2 == 0) ? cfg.m_xx : cfg.m_yx;
        assign cb  = (o % 2 == 0) ? cfg.m_xy : cfg.m_yy;
        assign off = (o % 2 == 0) ? cfg.offset_x : cfg.offset_y;
        assign px  = $signed(in_data.pt[(o / 2) * 2]);
        assign py  = $signed(in_data.pt[(o / 2) * 2 + 1]);

        always_ff @(posedge aclk) begin
            if (rdy1) begin
                pa_reg[o] <= ca * px;
                pb_reg[o] <= cb * py;
            end
        end

        // Exact sum, one rounding to Q16, offset, clamp to 32 bits
        assign sum = 66'(pa_reg[o]) + 66'(pb_reg[o]);
        assign rs  = (sum + 66'(RND_HALF)) >>> 30;
        assign v   = $signed(rs[36:0]) + 37'(off);

        always_ff @(posedge aclk) begin
            if (rdy2) begin
                if (v > 37'sd2147483647) begin
                    o_reg[o] <= 32'h7FFF_FFFF;
                end else if (v < -37'sd2147483648) begin
                    o_reg[o] <= 32'h8000_0000;
                end else begin
                    o_reg[o] <= v[31:0];
                end
            end
        end

        assign out_coord[o] = o_reg[o];
    end

    assign out_valid = v2_reg;
    assign out_last  = l2_reg;

endmodule

>>> rtl/core/arc_to_bezier_segments.sv
// Top level: arc angle in, transformed cubic Bezier segments out.
// Depends on atb_pkg, atb_cordic, atb_div, atb_seg and atb_xform.
//
//  Channel  Dir  Width  Contents
//  s_       in   24     arc_angle [18:0], zero fill above
//  m_       out  192    ctrl1_x ctrl1_y ctrl2_x ctrl2_y end_x end_y, tlast=last_segment
//  cfg_     in   32     write-only register port, index 0..5
//
// One arc word is accepted per cycle while s_tready is high, into a pipeline of 67
// register stages; it then leaves as 0 to 4 result words, one per cycle while m_tready
// is high. The sequencer that feeds the transform stage holds each arc that has
// segments until its last one is taken, and only then accepts the next arc.
// Reset (synchronous, active low) clears all valid bits and restores the
// identity transform. A stall on m_ holds every word in place; empty
// pipeline slots still fill from s_ while the output waits.
module arc_to_bezier_segments (
    input  logic         aclk,
    input  logic         aresetn,
    // arc_angle [18:0]
    input  logic [23:0]  s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // ctrl1_x [31:0], ctrl1_y [63:32], ctrl2_x [95:64], ctrl2_y [127:96],
    // end_x [159:128], end_y [191:160]
    output logic [191:0] m_tdata,
    output logic         m_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata
);
    import atb_pkg::*;

    cfg_t            cfg_reg;
    cord_t           cord_w;
    rem_t            rem_w;
    seg_t            seg_w;
    logic            cord_v, cord_r;
    logic            rem_v, rem_r;
    logic            seg_v, seg_r;
    logic [5:0][31:0] coord_w;

    // Config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.m_xx     <= 32'sd65536;
            cfg_reg.m_yx     <= '0;
            cfg_reg.m_xy     <= '0;
            cfg_reg.m_yy     <= 32'sd65536;
            cfg_reg.offset_x <= '0;
            cfg_reg.offset_y <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_M_XX:     cfg_reg.m_xx     <= cfg_wdata;
                REG_M_YX:     cfg_reg.m_yx     <= cfg_wdata;
                REG_M_XY:     cfg_reg.m_xy     <= cfg_wdata;
                REG_M_YY:     cfg_reg.m_yy     <= cfg_wdata;
                REG_OFFSET_X: cfg_reg.offset_x <= cfg_wdata;
                REG_OFFSET_Y: cfg_reg.offset_y <= cfg_wdata;
                default: ;
            endcase
        end
    end

    atb_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .arc_angle (s_tdata[18:0]),
        .out_valid (cord_v),
        .out_ready (cord_r),
        .out_data  (cord_w)
    );

    atb_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cord_v),
        .in_ready  (cord_r),
        .in_data   (cord_w),
        .out_valid (rem_v),
        .out_ready (rem_r),
        .out_data  (rem_w)
    );

    atb_seg u_seg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rem_v),
        .in_ready  (rem_r),
        .in_data   (rem_w),
        .out_valid (seg_v),
        .out_ready (seg_r),
        .out_data  (seg_w)
    );

    atb_xform u_xform (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (seg_v),
        .in_ready  (seg_r),
        .in_data   (seg_w),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_coord (coord_w),
        .out_last  (m_tlast)
    );

    assign m_tdata = coord_w;

endmodule
